[design/pbo_pkg.sv]
// ----------------------------------------------------------------------------
// pbo_pkg
// Shared types and constants for the polyblep oscillator with lowpass:
// configuration record, register map, wave codes and multiplier request.
// ----------------------------------------------------------------------------
package pbo_pkg;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register map, index = paddr / 4
  localparam logic [2:0] REG_PHASE_INC = 3'd0;
  localparam logic [2:0] REG_INV_INC   = 3'd1;
  localparam logic [2:0] REG_WAVE      = 3'd2;
  localparam logic [2:0] REG_POLE      = 3'd3;
  localparam logic [2:0] REG_VELOCITY  = 3'd4;
  localparam logic [2:0] REG_MIX       = 3'd5;
  localparam logic [2:0] REG_ENABLE    = 3'd6;

  // wave codes
  localparam logic [2:0] WAVE_OFF      = 3'd0;
  localparam logic [2:0] WAVE_SAW      = 3'd1;
  localparam logic [2:0] WAVE_SQUARE   = 3'd2;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
  localparam logic [2:0] WAVE_SINE     = 3'd4;

  typedef struct packed {
    logic [31:0] phase_inc;
    logic [31:0] inv_inc;
    logic [2:0]  wave;
    logic [15:0] pole;
    logic [15:0] velocity;
    logic [15:0] mix;
    logic        enable;
  } pbo_cfg_t;

  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } pbo_mul_req_t;

endpackage

[design/pbo_if.sv]
// ----------------------------------------------------------------------------
// pbo_if
// Stream channels of the oscillator block: stereo sample in, stereo sample out.
// ----------------------------------------------------------------------------
interface pbo_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          block_end_in;

  modport source (output valid, left_in, right_in, block_end_in, input ready);
  modport sink (input valid, left_in, right_in, block_end_in, output ready);
endinterface

interface pbo_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          block_end_out;

  modport source (output valid, left_out, right_out, block_end_out, input ready);
  modport sink (input valid, left_out, right_out, block_end_out, output ready);
endinterface

[design/pbo_mul.sv]
// ----------------------------------------------------------------------------
// pbo_mul
// Shared signed multiplier with a registered product, loaded when requested.
// ----------------------------------------------------------------------------
module pbo_mul (
  input  logic                                 clk_i,
  input  pbo_pkg::pbo_mul_req_t                req_i,
  output logic signed [pbo_pkg::PROD_W-1:0]    prod_o
);
  import pbo_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= PROD_W'($signed(req_i.a)) * PROD_W'($signed(req_i.b));
    end
  end

  assign prod_o = prod_q;

endmodule

[design/pbo_regs.sv]
// ----------------------------------------------------------------------------
// pbo_regs
// APB-style configuration registers: write on the access cycle, read back.
// ----------------------------------------------------------------------------
module pbo_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbo_pkg::ADDR_W-1:0]   paddr,
  input  logic [pbo_pkg::DATA_W-1:0]   pwdata,
  output logic [pbo_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output pbo_pkg::pbo_cfg_t            cfg_o
);
  import pbo_pkg::*;

  pbo_cfg_t   cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PHASE_INC: cfg_q.phase_inc <= pwdata;
        REG_INV_INC:   cfg_q.inv_inc   <= pwdata;
        REG_WAVE:      cfg_q.wave      <= pwdata[2:0];
        REG_POLE:      cfg_q.pole      <= pwdata[15:0];
        REG_VELOCITY:  cfg_q.velocity  <= pwdata[15:0];
        REG_MIX:       cfg_q.mix       <= pwdata[15:0];
        REG_ENABLE:    cfg_q.enable    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PHASE_INC: prdata = cfg_q.phase_inc;
      REG_INV_INC:   prdata = cfg_q.inv_inc;
      REG_WAVE:      prdata = DATA_W'(cfg_q.wave);
      REG_POLE:      prdata = DATA_W'(cfg_q.pole);
      REG_VELOCITY:  prdata = DATA_W'(cfg_q.velocity);
      REG_MIX:       prdata = DATA_W'(cfg_q.mix);
      REG_ENABLE:    prdata = DATA_W'(cfg_q.enable);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[design/pbo_core.sv]
// ----------------------------------------------------------------------------
// pbo_core
// Sequencer and datapath: waveform with BLEP corrections, sine polynomial,
// one-pole lowpass, gain and saturating mix; products use the shared multiplier.
// ----------------------------------------------------------------------------
module pbo_core #(
  parameter int SAMPLE_BITS     = 24,
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pbo_pkg::pbo_cfg_t                   cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       in_left_i,
  input  logic signed [SAMPLE_BITS-1:0]       in_right_i,
  input  logic                                in_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       out_left_o,
  output logic signed [SAMPLE_BITS-1:0]       out_right_o,
  output logic                                out_end_o,
  output pbo_pkg::pbo_mul_req_t               mul_req_o,
  input  logic signed [pbo_pkg::PROD_W-1:0]   mul_prod_i
);
  import pbo_pkg::*;

  localparam int ACC_W  = 36;
  localparam int OSC_W  = 34;
  localparam int OscShr = (SAMPLE_BITS <= 31) ? 31 - SAMPLE_BITS : 0;
  localparam int OscShl = (SAMPLE_BITS > 31) ? 1 : 0;

  localparam logic [30:0] One31 = 31'h4000_0000;
  localparam logic signed [OSC_W-1:0] OneOsc = OSC_W'(34'sh0_4000_0000);
  localparam logic signed [OSC_W-1:0] ThreeOsc = OSC_W'(34'sh0_C000_0000);
  localparam logic signed [ACC_W-1:0] OneAcc = ACC_W'(36'sh0_4000_0000);
  localparam logic signed [ACC_W-1:0] SMax =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMin = ~SMax;
  localparam logic signed [PROD_W-1:0] RoundQ30 = {{(PROD_W-30){1'b0}}, {30{1'b1}}};
  localparam logic signed [31:0] SineCoef [6] = '{
    32'sd1686629713, -32'sd693598668, 32'sd85569306,
    -32'sd5026995, 32'sd172272, -32'sd3864
  };

  typedef enum logic [4:0] {
    ST_IDLE, ST_BLEP_MUL, ST_BLEP_DIFF, ST_BLEP_SQ, ST_BLEP_ACC,
    ST_SIN_X2M, ST_SIN_X2, ST_SIN_MUL, ST_SIN_ACC, ST_SIN_FMUL, ST_SIN_FIN,
    ST_SHAPE, ST_LP_DIFF, ST_LP_MUL, ST_LP_ADD, ST_VEL_MUL, ST_VEL_SH,
    ST_MIX_MUL, ST_MIX_SH, ST_SUM, ST_DONE
  } state_e;

  function automatic logic signed [ACC_W-1:0] q30_trunc(
    input logic signed [PROD_W-1:0] v
  );
    logic signed [PROD_W-1:0] adj;
    adj = v + (v[PROD_W-1] ? RoundQ30 : '0);
    return ACC_W'(adj >>> 30);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] c;
    c = (v > SMax) ? SMax : ((v < SMin) ? SMin : v);
    return SAMPLE_BITS'(c);
  endfunction

  state_e                        state_q, state_d;
  logic [PHASE_BITS-1:0]         phase_q, phase_d;
  logic signed [SAMPLE_BITS-1:0] z_q, z_d;
  logic signed [SAMPLE_BITS-1:0] left_q, left_d, right_q, right_d;
  logic                          end_q, end_d;
  logic [31:0]                   t_q, t_d;
  logic                          sub_q, sub_d, second_q, second_d, low_q, low_d;
  logic [30:0]                   d_q, d_d, x2_q, x2_d;
  logic signed [ACC_W-1:0]       acc_q, acc_d;
  logic signed [OSC_W-1:0]       osc_q, osc_d;
  logic signed [SAMPLE_BITS-1:0] xs_q, xs_d;
  logic [2:0]                    k_q, k_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] out_left_q, out_left_d, out_right_q, out_right_d;
  logic                          out_end_q, out_end_d;

  logic [31:0]                   p_top;
  logic [PHASE_BITS-1:0]         inc_ext;

  if (PHASE_BITS >= 32) begin : g_phase_wide
    assign p_top   = phase_q[PHASE_BITS-1 -: 32];
    assign inc_ext = PHASE_BITS'(cfg_i.phase_inc) << (PHASE_BITS - 32);
  end else begin : g_phase_narrow
    assign p_top   = {phase_q, {(32-PHASE_BITS){1'b0}}};
    assign inc_ext = cfg_i.phase_inc[31 -: PHASE_BITS];
  end

  logic                             active;
  logic                             in_fire;
  logic                             out_free;
  logic [SINE_TABLE_BITS-1:0]       sin_idx;
  logic [30:0]                      sin_raw;
  logic [30:0]                      sin_x;
  logic                             blep_low;
  logic                             blep_high;
  logic [PROD_W-19:0]               blep_u;
  logic signed [OSC_W-1:0]          blep_sq;
  logic signed [ACC_W-1:0]          prod_q30;
  logic signed [ACC_W-1:0]          sin_clamp;
  logic signed [OSC_W:0]            osc_scaled;

  assign active   = cfg_i.enable && (cfg_i.wave != WAVE_OFF) && (cfg_i.mix != 16'd0);
  assign in_fire  = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  assign sin_idx = p_top[31 -: SINE_TABLE_BITS];
  assign sin_raw = 31'(sin_idx[SINE_TABLE_BITS-3:0]) << (32 - SINE_TABLE_BITS);
  assign sin_x   = sin_idx[SINE_TABLE_BITS-2] ? (One31 - sin_raw) : sin_raw;

  assign blep_low  = t_q < cfg_i.phase_inc;
  assign blep_high = ({1'b0, t_q} + {1'b0, cfg_i.phase_inc}) > 33'h1_0000_0000;
  assign blep_u    = mul_prod_i[PROD_W-1:18];
  assign blep_sq   = $signed(OSC_W'(mul_prod_i[PROD_W-1:30]));
  assign prod_q30  = q30_trunc(mul_prod_i);
  assign sin_clamp = prod_q30[ACC_W-1] ? '0 : ((prod_q30 > OneAcc) ? OneAcc : prod_q30);
  assign osc_scaled = ((OSC_W+1)'(osc_q) <<< OscShl) >>> OscShr;

  // multiplier operand select
  always_comb begin
    mul_req_o = '0;
    unique case (state_q)
      ST_BLEP_MUL: begin
        mul_req_o.en = blep_low || blep_high;
        mul_req_o.a  = blep_low ? $signed(MUL_W'(t_q))
                                : $signed(MUL_W'(33'h1_0000_0000 - {1'b0, t_q}));
        mul_req_o.b  = $signed(MUL_W'(cfg_i.inv_inc));
      end
      ST_BLEP_SQ, ST_SIN_X2M: begin
        mul_req_o.en = 1'b1;
        mul_req_o.a  = $signed(MUL_W'(d_q));
        mul_req_o.b  = $signed(MUL_W'(d_q));
      end
      ST_SIN_MUL: begin
        mul_req_o.en = 1'b1;
        mul_req_o.a  = $signed(acc_q[MUL_W-1:0]);
        mul_req_o.b  = $signed(MUL_W'(x2_q));
      end
      ST_SIN_FMUL: begin
        mul_req_o.en = 1'b1;
        mul_req_o.a  = $signed(acc_q[MUL_W-1:0]);
        mul_req_o.b  = $signed(MUL_W'(d_q));
      end
      ST_LP_MUL: begin
        mul_req_o.en = 1'b1;
        mul_req_o.a  = $signed(acc_q[MUL_W-1:0]);
        mul_req_o.b  = $signed(MUL_W'(cfg_i.pole));
      end
      ST_VEL_MUL: begin
        mul_req_o.en = 1'b1;
        mul_req_o.a  = MUL_W'(z_q);
        mul_req_o.b  = $signed(MUL_W'(cfg_i.velocity));
      end
      ST_MIX_MUL: begin
        mul_req_o.en = 1'b1;
        mul_req_o.a  = $signed(acc_q[MUL_W-1:0]);
        mul_req_o.b  = $signed(MUL_W'(cfg_i.mix));
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    z_d         = z_q;
    left_d      = left_q;
    right_d     = right_q;
    end_d       = end_q;
    t_d         = t_q;
    sub_d       = sub_q;
    second_d    = second_q;
    low_d       = low_q;
    d_d         = d_q;
    x2_d        = x2_q;
    acc_d       = acc_q;
    osc_d       = osc_q;
    xs_d        = xs_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_left_d  = out_left_q;
    out_right_d = out_right_q;
    out_end_d   = out_end_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          left_d  = in_left_i;
          right_d = in_right_i;
          end_d   = in_end_i;
          if (active) begin
            phase_d  = phase_q + inc_ext;
            t_d      = p_top;
            d_d      = sin_x;
            acc_d    = ACC_W'(SineCoef[5]);
            k_d      = 3'd4;
            sub_d    = (cfg_i.wave == WAVE_SAW);
            second_d = (cfg_i.wave == WAVE_SQUARE);
            unique case (cfg_i.wave)
              WAVE_SAW: begin
                osc_d   = $signed(OSC_W'(p_top >> 1)) - OneOsc;
                state_d = ST_BLEP_MUL;
              end
              WAVE_SQUARE: begin
                osc_d   = p_top[31] ? -OneOsc : OneOsc;
                state_d = ST_BLEP_MUL;
              end
              WAVE_TRIANGLE: begin
                osc_d   = p_top[31] ? (ThreeOsc - $signed(OSC_W'(p_top)))
                                    : ($signed(OSC_W'(p_top)) - OneOsc);
                state_d = ST_SHAPE;
              end
              WAVE_SINE: begin
                osc_d   = '0;
                state_d = ST_SIN_X2M;
              end
              default: begin
                osc_d   = '0;
                state_d = ST_SHAPE;
              end
            endcase
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_BLEP_MUL: begin
        low_d = blep_low;
        if (blep_low || blep_high) begin
          state_d = ST_BLEP_DIFF;
        end else if (second_q) begin
          t_d      = t_q ^ 32'h8000_0000;
          second_d = 1'b0;
          sub_d    = 1'b1;
        end else begin
          state_d = ST_SHAPE;
        end
      end
      ST_BLEP_DIFF: begin
        d_d     = (blep_u >= (PROD_W-18)'(One31)) ? '0 : (One31 - blep_u[30:0]);
        state_d = ST_BLEP_SQ;
      end
      ST_BLEP_SQ: begin
        state_d = ST_BLEP_ACC;
      end
      ST_BLEP_ACC: begin
        osc_d = (low_q ^ sub_q) ? (osc_q - blep_sq) : (osc_q + blep_sq);
        if (second_q) begin
          t_d      = t_q ^ 32'h8000_0000;
          second_d = 1'b0;
          sub_d    = 1'b1;
          state_d  = ST_BLEP_MUL;
        end else begin
          state_d = ST_SHAPE;
        end
      end
      ST_SIN_X2M: begin
        state_d = ST_SIN_X2;
      end
      ST_SIN_X2: begin
        x2_d    = prod_q30[30:0];
        state_d = ST_SIN_MUL;
      end
      ST_SIN_MUL: begin
        state_d = ST_SIN_ACC;
      end
      ST_SIN_ACC: begin
        acc_d = ACC_W'(SineCoef[k_q]) + prod_q30;
        if (k_q == 3'd0) begin
          state_d = ST_SIN_FMUL;
        end else begin
          k_d     = k_q - 3'd1;
          state_d = ST_SIN_MUL;
        end
      end
      ST_SIN_FMUL: begin
        state_d = ST_SIN_FIN;
      end
      ST_SIN_FIN: begin
        osc_d   = t_q[31] ? -OSC_W'(sin_clamp) : OSC_W'(sin_clamp);
        state_d = ST_SHAPE;
      end
      ST_SHAPE: begin
        xs_d    = sat_sample(ACC_W'(osc_scaled));
        state_d = ST_LP_DIFF;
      end
      ST_LP_DIFF: begin
        acc_d   = ACC_W'(z_q) - ACC_W'(xs_q);
        state_d = ST_LP_MUL;
      end
      ST_LP_MUL: begin
        state_d = ST_LP_ADD;
      end
      ST_LP_ADD: begin
        z_d     = SAMPLE_BITS'(ACC_W'(xs_q) + ACC_W'(mul_prod_i >>> 16));
        state_d = ST_VEL_MUL;
      end
      ST_VEL_MUL: begin
        state_d = ST_VEL_SH;
      end
      ST_VEL_SH: begin
        acc_d   = ACC_W'(mul_prod_i >>> 15);
        state_d = ST_MIX_MUL;
      end
      ST_MIX_MUL: begin
        state_d = ST_MIX_SH;
      end
      ST_MIX_SH: begin
        acc_d   = ACC_W'(mul_prod_i >>> 15);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        left_d  = sat_sample(ACC_W'(left_q) + acc_q);
        right_d = sat_sample(ACC_W'(right_q) + acc_q);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_left_d  = left_q;
          out_right_d = right_q;
          out_end_d   = end_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      z_q         <= '0;
      left_q      <= '0;
      right_q     <= '0;
      end_q       <= 1'b0;
      t_q         <= '0;
      sub_q       <= 1'b0;
      second_q    <= 1'b0;
      low_q       <= 1'b0;
      d_q         <= '0;
      x2_q        <= '0;
      acc_q       <= '0;
      osc_q       <= '0;
      xs_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_left_q  <= '0;
      out_right_q <= '0;
      out_end_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      z_q         <= z_d;
      left_q      <= left_d;
      right_q     <= right_d;
      end_q       <= end_d;
      t_q         <= t_d;
      sub_q       <= sub_d;
      second_q    <= second_d;
      low_q       <= low_d;
      d_q         <= d_d;
      x2_q        <= x2_d;
      acc_q       <= acc_d;
      osc_q       <= osc_d;
      xs_q        <= xs_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      out_left_q  <= out_left_d;
      out_right_q <= out_right_d;
      out_end_q   <= out_end_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;
  assign out_end_o   = out_end_q;

endmodule

[design/polyblep_oscillator_lowpass.sv]
// ----------------------------------------------------------------------------
// polyblep_oscillator_lowpass
// PolyBLEP / triangle / sine oscillator with one-pole lowpass, scaled and
// mixed with saturation into a stereo sample stream.
//
//   channel   dir   handshake            payload
//   in_i      in    valid / ready        left_in, right_in, block_end_in
//   out_o     out   valid / ready        left_out, right_out, block_end_out
//   apb       in    psel/penable/pready  paddr, pwdata, prdata
//
// after an input transfer the block is busy until its result is registered for out_o:
// bypass goes straight to the output step, triangle and unused wave codes skip to shaping,
// saw and square add the BLEP steps for each correction that fires (square checks both edges), sine runs the polynomial
// every product goes through the one shared 34 x 34 multiplier
// reset clears phase and lowpass memory; the block is ready right after reset
// a result waiting at out_o holds the next one in its last step
// ----------------------------------------------------------------------------
module polyblep_oscillator_lowpass #(
  parameter int SAMPLE_BITS     = 24,
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pbo_in_if.sink                       in_i,
  pbo_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbo_pkg::ADDR_W-1:0]   paddr,
  input  logic [pbo_pkg::DATA_W-1:0]   pwdata,
  output logic [pbo_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import pbo_pkg::*;

  pbo_cfg_t                 cfg;
  pbo_mul_req_t             mul_req;
  logic signed [PROD_W-1:0] mul_prod;

  pbo_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pbo_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_prod)
  );

  pbo_core #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_left_i   (in_i.left_in),
    .in_right_i  (in_i.right_in),
    .in_end_i    (in_i.block_end_in),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_left_o  (out_o.left_out),
    .out_right_o (out_o.right_out),
    .out_end_o   (out_o.block_end_out),
    .mul_req_o   (mul_req),
    .mul_prod_i  (mul_prod)
  );

endmodule

[design/pbo_checker.sv]
// ----------------------------------------------------------------------------
// pbo_checker
// Port-level checks: busy after each input, no invented results, bounded
// backlog, stalled output holds.
// ----------------------------------------------------------------------------
module pbo_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_left_i,
  input logic [SAMPLE_BITS-1:0] out_right_i,
  input logic                   out_end_i
);

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pend_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // items taken in but not yet handed out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_fire) - 2'(out_fire);
    end
  end

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_i)
    else $error("input ready right after a transfer");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire |-> (pend_q != 2'd0))
    else $error("output transfer without a pending input");

  a_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_left_i) && $stable(out_right_i) && $stable(out_end_i)))
    else $error("stalled output changed");

endmodule

bind polyblep_oscillator_lowpass pbo_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_pbo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_left_i  (out_o.left_out),
  .out_right_i (out_o.right_out),
  .out_end_i   (out_o.block_end_out)
);
